@@ hdl/spvm_pkg.sv @@
// Shared types and constants for the space vector modulator step block.
// No dependencies; imported by the serial multiplier and the top level.
package spvm_pkg;

   // Operand and product widths of the shared shift-add multiplier.
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = 64;

   localparam int PPH_W    = 23;
   localparam int PERIOD_W = 16;
   localparam int FREQ_W   = 14;
   localparam int MOD_W    = 15;
   localparam int TIME_W   = 15;
   localparam int OUT_W    = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 23;
   localparam int SINE_W   = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_PER_HERTZ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD      = 2'd1;

   // Odd Taylor coefficients of sin(pi/2 * x), Q30.
   localparam logic [31:0] K1 = 32'd1686629713;
   localparam logic [31:0] K3 = 32'd693598668;
   localparam logic [31:0] K5 = 32'd85569306;
   localparam logic [31:0] K7 = 32'd5026995;
   localparam logic [31:0] K9 = 32'd172272;

   localparam logic [SINE_W-1:0] ONE_Q30 = 31'h4000_0000;
   // floor(v/3) == (v * RECIP3) >> 33 for every 32-bit v.
   localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
   localparam logic [MUL_P_W-1:0] HALF_Q45 = 64'h0000_1000_0000_0000;
   localparam logic [MUL_P_W-1:0] HALF_Q30 = 64'h0000_0000_2000_0000;
   localparam logic [TIME_W:0] TIME_MAX = 16'd32767;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   typedef enum logic [3:0] {
      OP_INC   = 4'd0,
      OP_DIV   = 4'd1,
      OP_SQ    = 4'd2,
      OP_P7    = 4'd3,
      OP_P5    = 4'd4,
      OP_P3    = 4'd5,
      OP_P1    = 4'd6,
      OP_FIN   = 4'd7,
      OP_PSUM  = 4'd8,
      OP_T0    = 4'd9,
      OP_MTS   = 4'd10,
      OP_D1    = 4'd11,
      OP_D2    = 4'd12,
      OP_ALPHA = 4'd13,
      OP_BETA  = 4'd14
   } op_type;

   function automatic logic [2:0] vec_first(input logic [2:0] k);
      logic [2:0] v;
      unique case (k)
         3'd0: v = 3'd1;
         3'd1: v = 3'd3;
         3'd2: v = 3'd3;
         3'd3: v = 3'd5;
         3'd4: v = 3'd5;
         default: v = 3'd1;
      endcase
      return v;
   endfunction

   function automatic logic [2:0] vec_second(input logic [2:0] k);
      logic [2:0] v;
      unique case (k)
         3'd0, 3'd1: v = 3'd2;
         3'd2, 3'd3: v = 3'd4;
         default:    v = 3'd6;
      endcase
      return v;
   endfunction

endpackage

@@ hdl/spvm_mul.sv @@
// Bit-serial shift-add multiplier shared by every product of the block.
// Depends on spvm_pkg for operand widths.
module spvm_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [spvm_pkg::MUL_A_W-1:0]  a_in,
   input  logic [spvm_pkg::MUL_B_W-1:0]  b_in,
   output logic                          done,
   output logic [spvm_pkg::MUL_P_W-1:0]  product
);
   import spvm_pkg::*;

   logic                busy_ff, busy_in;
   logic [MUL_P_W-1:0]  acc_ff, acc_in;
   logic [MUL_P_W-1:0]  mcand_ff, mcand_in;
   logic [MUL_B_W-1:0]  mplier_ff, mplier_in;

   // One multiplier bit per cycle; finishes as soon as no set bit remains.
   assign done    = busy_ff && (mplier_ff == '0);
   assign product = acc_ff;

   always_comb begin
      busy_in   = busy_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         acc_in    = '0;
         mcand_in  = MUL_P_W'(a_in);
         mplier_in = b_in;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

endmodule

@@ hdl/space_vector_modulator_step_top.sv @@
// Top level of the two-level three-phase space vector modulator step.
// Depends on spvm_pkg and spvm_mul.
//
// Usage: each beat on the req_ channel is one PWM update (frequency and
// modulation index). The block advances its phase accumulator, then gives
// one beat on the rsp_ channel with the sector, the three dwell times, the
// active vector pair, the alpha/beta reference and the overmodulation flag.
// The csr_ port writes phase_per_hertz (index 0) and pwm_period (index 1);
// write it only while no update is in flight.
// Every product runs through one shift-add multiplier, one bit of the
// multiplier operand per cycle. An update takes 34 products; the next
// update is accepted once the result is in the output register.
// Reset clears the phase and both registers and empties the output.
// While rsp_stall is high the result beat holds; a new request may already
// be accepted and computed, and then waits until the output is free.
module space_vector_modulator_step_top #(
   parameter int PHASE_BITS = 24,
   parameter int ANGLE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [spvm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [spvm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [spvm_pkg::FREQ_W-1:0]         req_frequency,
   input  logic [spvm_pkg::MOD_W-1:0]          req_mod_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [3:0]                          rsp_sector,
   output logic [spvm_pkg::TIME_W-1:0]         rsp_zero_time,
   output logic [spvm_pkg::TIME_W-1:0]         rsp_first_time,
   output logic [spvm_pkg::TIME_W-1:0]         rsp_second_time,
   output logic [2:0]                          rsp_first_vector,
   output logic [2:0]                          rsp_second_vector,
   output logic signed [spvm_pkg::OUT_W-1:0]   rsp_alpha_out,
   output logic signed [spvm_pkg::OUT_W-1:0]   rsp_beta_out,
   output logic                                rsp_overmodulated
);
   import spvm_pkg::*;

   localparam int INC_SHIFT = 36 - PHASE_BITS;
   localparam int SH_R = (PHASE_BITS >= ANGLE_BITS) ? PHASE_BITS - ANGLE_BITS : 0;
   localparam int SH_L = (PHASE_BITS >= ANGLE_BITS) ? 0 : ANGLE_BITS - PHASE_BITS;
   localparam int DIV_SHIFT = 31 - ANGLE_BITS;
   localparam int X_SHIFT = 32 - ANGLE_BITS;
   localparam logic [ANGLE_BITS:0] ANGLE_ONE = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   // Quarter-turn argument of the sine of a turn fraction.
   function automatic logic [SINE_W-1:0] quarter_arg(input logic [ANGLE_BITS-1:0] a);
      logic [ANGLE_BITS-2:0] r;
      r = {1'b0, a[ANGLE_BITS-3:0]};
      if (a[ANGLE_BITS-2]) begin
         r = QUARTER[ANGLE_BITS-2:0] - r;
      end
      return SINE_W'(r) << X_SHIFT;
   endfunction

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic                     issued_ff, issued_in;
   logic [1:0]               sel_ff, sel_in;
   logic [PHASE_BITS-1:0]    phase_ff, phase_in;
   logic [PPH_W-1:0]         pph_ff;
   logic [PERIOD_W-1:0]      period_ff;
   logic [FREQ_W-1:0]        freq_ff;
   logic [MOD_W-1:0]         mod_ff;
   logic [SINE_W-1:0]        x_ff, x_in;
   logic [SINE_W-1:0]        x2_ff, x2_in;
   logic [31:0]              r_ff, r_in;
   logic [SINE_W-1:0]        s1_ff, s2_ff, cmag_ff, smag_ff;
   logic                     cneg_ff, sneg_ff;
   logic [46:0]              p_ff;
   logic [30:0]              mts_ff;
   logic [TIME_W-1:0]        t0_ff, t1_ff, t2_ff;
   logic                     over_ff;
   logic [OUT_W-1:0]         alpha_ff, beta_ff;

   logic                     mul_start, mul_done;
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [MUL_P_W-1:0]       prod;

   logic [ANGLE_BITS-1:0]    angle, f, cos_angle;
   logic [ANGLE_BITS+3:0]    ang12;
   logic [ANGLE_BITS+2:0]    ang6;
   logic [3:0]               sec12;
   logic [2:0]               k6;
   logic [ANGLE_BITS:0]      f_rest;
   logic [31:0]              dv0, dv1;
   logic [SINE_W-1:0]        div_q, sine_res;
   logic [MUL_P_W-1:0]       prod_q30, rnd45, rnd30;
   logic [TIME_W-1:0]        time_sat;
   logic [OUT_W-1:0]         ref_mag;
   logic                     accept, out_free;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   spvm_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a_in    (mul_a),
      .b_in    (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   // Angle, sector and in-sector fraction follow the phase register.
   assign angle     = ANGLE_BITS'((64'(phase_ff) >> SH_R) << SH_L);
   assign ang12     = (ANGLE_BITS+4)'(angle) * (ANGLE_BITS+4)'(12);
   assign ang6      = (ANGLE_BITS+3)'(angle) * (ANGLE_BITS+3)'(6);
   assign sec12     = ang12[ANGLE_BITS+3:ANGLE_BITS];
   assign k6        = ang6[ANGLE_BITS+2:ANGLE_BITS];
   assign f         = ang6[ANGLE_BITS-1:0];
   assign f_rest    = ANGLE_ONE - {1'b0, f};
   assign dv0       = 32'(f) << DIV_SHIFT;
   assign dv1       = 32'(f_rest) << DIV_SHIFT;
   assign cos_angle = angle + QUARTER;

   assign div_q    = (prod[63:33] > ONE_Q30) ? ONE_Q30 : prod[63:33];
   assign prod_q30 = prod >> 30;
   assign sine_res = (prod_q30 > MUL_P_W'(ONE_Q30)) ? ONE_Q30 : prod_q30[SINE_W-1:0];
   assign rnd45    = (prod + HALF_Q45) >> 45;
   assign rnd30    = (prod + HALF_Q30) >> 30;
   assign time_sat = (rnd45 > MUL_P_W'(TIME_MAX)) ? TIME_MAX[TIME_W-1:0] : rnd45[TIME_W-1:0];
   assign ref_mag  = (rnd30 > MUL_P_W'(TIME_MAX)) ? TIME_MAX : rnd30[OUT_W-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op_ff)
         OP_INC: begin
            mul_a = MUL_A_W'(pph_ff);
            mul_b = MUL_B_W'(freq_ff);
         end
         OP_DIV: begin
            mul_a = MUL_A_W'(sel_ff[0] ? dv1 : dv0);
            mul_b = RECIP3;
         end
         OP_SQ: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = MUL_B_W'(x_ff);
         end
         OP_P7, OP_P5, OP_P3, OP_P1: begin
            mul_a = MUL_A_W'(x2_ff);
            mul_b = r_ff;
         end
         OP_FIN: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = r_ff;
         end
         OP_PSUM: begin
            mul_a = MUL_A_W'(s1_ff) + MUL_A_W'(s2_ff);
            mul_b = MUL_B_W'(mod_ff);
         end
         OP_T0: begin
            // Past full modulation the zero time is clamped to zero.
            mul_a = (MUL_P_W'(p_ff) > HALF_Q45) ? '0
                  : MUL_A_W'(HALF_Q45) - MUL_A_W'(p_ff);
            mul_b = MUL_B_W'(period_ff);
         end
         OP_MTS: begin
            mul_a = MUL_A_W'(period_ff);
            mul_b = MUL_B_W'(mod_ff);
         end
         OP_D1: begin
            mul_a = MUL_A_W'(mts_ff);
            mul_b = MUL_B_W'(s1_ff);
         end
         OP_D2: begin
            mul_a = MUL_A_W'(mts_ff);
            mul_b = MUL_B_W'(s2_ff);
         end
         OP_ALPHA: begin
            mul_a = MUL_A_W'(cmag_ff);
            mul_b = MUL_B_W'(mod_ff);
         end
         OP_BETA: begin
            mul_a = MUL_A_W'(smag_ff);
            mul_b = MUL_B_W'(mod_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_start = (state_ff == ST_RUN) && !issued_ff;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      issued_in = issued_ff;
      sel_in    = sel_ff;
      phase_in  = phase_ff;
      x_in      = x_ff;
      x2_in     = x2_ff;
      r_in      = r_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_RUN;
               op_in     = OP_INC;
               issued_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (mul_start) begin
               issued_in = 1'b1;
            end
            if (mul_done) begin
               issued_in = 1'b0;
               case (op_ff)
                  OP_INC: begin
                     phase_in = phase_ff + prod[INC_SHIFT +: PHASE_BITS];
                     sel_in   = 2'd0;
                     op_in    = OP_DIV;
                  end
                  OP_DIV: begin
                     x_in  = div_q;
                     op_in = OP_SQ;
                  end
                  OP_SQ: begin
                     x2_in = prod[60:30];
                     r_in  = K9;
                     op_in = OP_P7;
                  end
                  OP_P7: begin
                     r_in  = K7 - prod_q30[31:0];
                     op_in = OP_P5;
                  end
                  OP_P5: begin
                     r_in  = K5 - prod_q30[31:0];
                     op_in = OP_P3;
                  end
                  OP_P3: begin
                     r_in  = K3 - prod_q30[31:0];
                     op_in = OP_P1;
                  end
                  OP_P1: begin
                     r_in  = K1 - prod_q30[31:0];
                     op_in = OP_FIN;
                  end
                  OP_FIN: begin
                     // Sine order: second dwell, first dwell, cosine, sine.
                     if (sel_ff == 2'd0) begin
                        sel_in = 2'd1;
                        op_in  = OP_DIV;
                     end else if (sel_ff == 2'd1) begin
                        sel_in = 2'd2;
                        x_in   = quarter_arg(cos_angle);
                        op_in  = OP_SQ;
                     end else if (sel_ff == 2'd2) begin
                        sel_in = 2'd3;
                        x_in   = quarter_arg(angle);
                        op_in  = OP_SQ;
                     end else begin
                        op_in  = OP_PSUM;
                     end
                  end
                  OP_PSUM:  op_in = OP_T0;
                  OP_T0:    op_in = OP_MTS;
                  OP_MTS:   op_in = OP_D1;
                  OP_D1:    op_in = OP_D2;
                  OP_D2:    op_in = OP_ALPHA;
                  OP_ALPHA: op_in = OP_BETA;
                  default:  state_in = ST_HOLD;
               endcase
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         op_ff     <= OP_INC;
         issued_ff <= 1'b0;
         sel_ff    <= 2'd0;
         phase_ff  <= '0;
         pph_ff    <= '0;
         period_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         issued_ff <= issued_in;
         sel_ff    <= sel_in;
         phase_ff  <= phase_in;
         if (csr_we && csr_index == CSR_PHASE_PER_HERTZ) begin
            pph_ff <= csr_wdata[PPH_W-1:0];
         end
         if (csr_we && csr_index == CSR_PWM_PERIOD) begin
            period_ff <= csr_wdata[PERIOD_W-1:0];
         end
         if (state_ff == ST_HOLD && out_free) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   // Datapath registers; no reset needed.
   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      x2_ff <= x2_in;
      r_ff  <= r_in;
      if (accept) begin
         freq_ff <= req_frequency;
         mod_ff  <= req_mod_index;
      end
      if (state_ff == ST_RUN && op_ff == OP_FIN && mul_done) begin
         case (sel_ff)
            2'd0: s2_ff <= sine_res;
            2'd1: s1_ff <= sine_res;
            2'd2: cmag_ff <= sine_res;
            default: smag_ff <= sine_res;
         endcase
      end
      if (state_ff == ST_RUN && op_ff == OP_FIN && mul_done && sel_ff == 2'd1) begin
         cneg_ff <= cos_angle[ANGLE_BITS-1];
         sneg_ff <= angle[ANGLE_BITS-1];
      end
      if (state_ff == ST_RUN && mul_done) begin
         case (op_ff)
            OP_PSUM: p_ff <= prod[46:0];
            OP_T0: begin
               t0_ff   <= time_sat;
               over_ff <= (MUL_P_W'(p_ff) > HALF_Q45) && (period_ff != '0);
            end
            OP_MTS:   mts_ff <= prod[30:0];
            OP_D1:    t1_ff <= time_sat;
            OP_D2:    t2_ff <= time_sat;
            OP_ALPHA: alpha_ff <= cneg_ff ? OUT_W'(0) - ref_mag : ref_mag;
            OP_BETA:  beta_ff <= sneg_ff ? OUT_W'(0) - ref_mag : ref_mag;
            default: begin
            end
         endcase
      end
      if (state_ff == ST_HOLD && out_free) begin
         rsp_sector        <= sec12 + 4'd1;
         rsp_zero_time     <= t0_ff;
         rsp_first_time    <= t1_ff;
         rsp_second_time   <= t2_ff;
         rsp_first_vector  <= vec_first(k6);
         rsp_second_vector <= vec_second(k6);
         rsp_alpha_out     <= alpha_ff;
         rsp_beta_out      <= beta_ff;
         rsp_overmodulated <= over_ff;
      end
   end

endmodule

@@ hdl/spvm_checker.sv @@
// Port-level checks for the space vector modulator step top level.
// Depends on space_vector_modulator_step_top; attached by the bind below.
module spvm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_sector,
   input logic [2:0]  rsp_first_vector,
   input logic [14:0] rsp_zero_time
);

   // Reset empties the output.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // An accepted beat keeps the input closed while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after accepting a beat");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sector >= 4'd1 && rsp_sector <= 4'd12 && rsp_first_vector[0]))
      else $error("sector or first vector out of range");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_zero_time)))
      else $error("stalled result beat changed");

endmodule

bind space_vector_modulator_step_top spvm_checker u_spvm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sector       (rsp_sector),
   .rsp_first_vector (rsp_first_vector),
   .rsp_zero_time    (rsp_zero_time)
);

@@ test/tb.sv @@
// Self-checking testbench for space_vector_modulator_step_top.
// Depends on spvm_pkg and the block's RTL; predicts every update beat and
// compares each result beat with the oldest prediction, under random idling.
`timescale 1ns / 1ps

module tb;
   import spvm_pkg::*;

   typedef struct packed {
      logic [3:0]        sector;
      logic [TIME_W-1:0] zero_time;
      logic [TIME_W-1:0] first_time;
      logic [TIME_W-1:0] second_time;
      logic [2:0]        first_vector;
      logic [2:0]        second_vector;
      logic [OUT_W-1:0]  alpha_out;
      logic [OUT_W-1:0]  beta_out;
      logic              overmodulated;
   } pwm_update_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int LONG_HOLD      = 3000;
   localparam longint Q30        = 64'd1 << 30;
   localparam longint HALF_TURN44 = 64'd1 << 44;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic [FREQ_W-1:0]     req_frequency;
   logic [MOD_W-1:0]      req_mod_index;
   logic                  rsp_valid;
   logic                  rsp_stall;
   pwm_update_type        got;

   pwm_update_type pending_updates[$];
   logic [23:0] model_phase;
   logic [22:0] model_pph;
   logic [15:0] model_period;
   int          mismatches;
   int          idle_cycles;
   bit          idling_on;
   bit          long_hold_req;

   space_vector_modulator_step_top u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_frequency(req_frequency), .req_mod_index(req_mod_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_sector(got.sector), .rsp_zero_time(got.zero_time),
      .rsp_first_time(got.first_time), .rsp_second_time(got.second_time),
      .rsp_first_vector(got.first_vector), .rsp_second_vector(got.second_vector),
      .rsp_alpha_out(got.alpha_out), .rsp_beta_out(got.beta_out),
      .rsp_overmodulated(got.overmodulated)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // sin(pi/2 * x) with x and result in Q30, nested odd polynomial.
   function automatic longint unsigned quarter_sine(longint unsigned x);
      longint unsigned x2, r, s;
      if (x > Q30) x = Q30;
      x2 = (x * x) >> 30;
      r = 64'd172272;
      r = 64'd5026995 - ((x2 * r) >> 30);
      r = 64'd85569306 - ((x2 * r) >> 30);
      r = 64'd693598668 - ((x2 * r) >> 30);
      r = 64'd1686629713 - ((x2 * r) >> 30);
      s = (x * r) >> 30;
      return (s > Q30) ? Q30 : s;
   endfunction

   // m times sine of a 16-bit turn fraction, signed Q2.14 with saturation.
   function automatic logic [15:0] scaled_sine(longint unsigned m, logic [15:0] a);
      longint unsigned r, v;
      r = a[13:0];
      if (a[14]) r = 64'd16384 - r;
      v = (m * quarter_sine(r << 16) + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      return a[15] ? 16'(-v) : 16'(v);
   endfunction

   function automatic longint unsigned sat_time(longint unsigned v);
      return (v > 32767) ? 64'd32767 : v;
   endfunction

   function automatic pwm_update_type advance_modulator(logic [13:0] freq, logic [14:0] mod);
      pwm_update_type e;
      longint unsigned m, ts, angle, k6, f, s1, s2, p;
      m = mod;
      ts = model_period;
      model_phase = model_phase + 24'((64'(freq) * model_pph) >> 12);
      angle = model_phase[23:8];
      k6 = (angle * 6) >> 16;
      f = angle * 6 - (k6 << 16);
      s2 = quarter_sine((f << 15) / 3);
      s1 = quarter_sine(((64'd65536 - f) << 15) / 3);
      p = m * (s1 + s2);
      e.sector = 4'(((angle * 12) >> 16) + 1);
      e.overmodulated = 1'b0;
      if (p > HALF_TURN44) begin
         e.zero_time = '0;
         e.overmodulated = (ts != 0);
      end else begin
         e.zero_time = 15'(sat_time((ts * (HALF_TURN44 - p) + HALF_TURN44) >> 45));
      end
      e.first_time = 15'(sat_time((m * ts * s1 + HALF_TURN44) >> 45));
      e.second_time = 15'(sat_time((m * ts * s2 + HALF_TURN44) >> 45));
      case (k6)
         0: begin e.first_vector = 3'd1; e.second_vector = 3'd2; end
         1: begin e.first_vector = 3'd3; e.second_vector = 3'd2; end
         2: begin e.first_vector = 3'd3; e.second_vector = 3'd4; end
         3: begin e.first_vector = 3'd5; e.second_vector = 3'd4; end
         4: begin e.first_vector = 3'd5; e.second_vector = 3'd6; end
         default: begin e.first_vector = 3'd1; e.second_vector = 3'd6; end
      endcase
      e.alpha_out = scaled_sine(m, 16'(angle + 16384));
      e.beta_out = scaled_sine(m, 16'(angle));
      return e;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      pwm_update_type exp_beat;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_updates.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %p", got);
         end else begin
            exp_beat = pending_updates.pop_front();
            if (exp_beat !== got) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected %p actual %p", exp_beat, got);
            end
         end
      end
   end

   // Receiver stall: random bursts, plus one long hold on request.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            for (n = 0; n < LONG_HOLD; n++) @(posedge clock);
            long_hold_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog over cycles without any accepted beat or register write.
   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_update(logic [13:0] freq, logic [14:0] mod);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_frequency <= freq;
      req_mod_index <= mod;
      do @(posedge clock); while (req_stall);
      pending_updates.push_back(advance_modulator(freq, mod));
   endtask

   // Waits for every result, then lets the block settle before a write.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic configure(logic [22:0] pph, logic [15:0] period);
      csr_we <= 1'b1;
      csr_index <= CSR_PHASE_PER_HERTZ;
      csr_wdata <= pph;
      @(posedge clock);
      csr_index <= CSR_PWM_PERIOD;
      csr_wdata <= 23'(period);
      @(posedge clock);
      csr_we <= 1'b0;
      model_pph = pph;
      model_period = period;
   endtask

   task automatic test_directed;
      configure('0, '0);
      send_update('0, '0);
      send_update(14'd16383, 15'd18919);
      drain();
      configure(23'h7FFFFF, 16'hFFFF);
      send_update(14'd16383, 15'd18919);
      send_update(14'd16383, 15'h7FFF);
      send_update(14'd1, 15'd0);
      send_update(14'd16383, 15'd16384);
      drain();
      // About one twelfth of a turn per update walks through every sector.
      configure(23'd5726623, 16'd40000);
      for (int i = 0; i < 13; i++) send_update(14'd1000, (i % 3 == 0) ? 15'd18919 : 15'd16384);
      drain();
      configure(23'd1234567, 16'd1);
      send_update(14'd77, 15'd8192);
      drain();
   endtask

   task automatic random_phase(int count);
      logic [14:0] mod;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: mod = 15'($urandom);
            1: mod = 15'($urandom_range(18000, 18919));
            default: mod = 15'($urandom_range(0, 18919));
         endcase
         send_update(14'($urandom), mod);
      end
   endtask

   task automatic test_random;
      logic [22:0] pph;
      logic [15:0] period;
      for (int k = 0; k < 10; k++) begin
         case (k % 4)
            0: begin pph = 23'($urandom); period = 16'($urandom); end
            1: begin pph = 23'($urandom_range(0, 4000)); period = 16'($urandom_range(0, 3)); end
            2: begin pph = 23'h7FFFFF; period = 16'hFFFF; end
            default: begin pph = 23'($urandom); period = 16'($urandom_range(100, 20000)); end
         endcase
         configure(pph, period);
         random_phase(130);
         drain();
      end
   endtask

   task automatic test_backpressure;
      long_hold_req = 1'b1;
      random_phase(20);
      drain();
   endtask

   task automatic test_steady_flow;
      idling_on = 1'b0;
      configure(23'($urandom), 16'($urandom));
      random_phase(200);
      drain();
   endtask

   initial begin
      mismatches = 0;
      idling_on = 1'b1;
      long_hold_req = 1'b0;
      model_phase = '0;
      model_pph = '0;
      model_period = '0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_frequency = '0;
      req_mod_index = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      test_steady_flow();
      repeat (1200) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/spvm_pkg.sv
hdl/spvm_mul.sv
hdl/space_vector_modulator_step_top.sv
hdl/spvm_checker.sv
test/tb.sv
